// ----- hdl/ecnq_pkg.sv -----
// Shared constants, types and codes for the ECN marking queue with pause.
// Used by ecnq_front, ecnq_back and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ecnq_pkg;

  localparam int FIFO_DEPTH   = 256;
  localparam int PTR_W        = $clog2(FIFO_DEPTH);
  localparam int CNT_W        = PTR_W + 1;
  localparam int SIZE_BITS    = 14;
  localparam int FLOW_ID_BITS = 16;
  localparam int DESC_W       = SIZE_BITS + FLOW_ID_BITS + 1;
  localparam int BYTES_W      = 24;
  localparam int QUANTA_W     = 16;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 3;
  localparam int LINK_W       = 2;
  localparam int CFG_IDX_W    = 1;

  localparam int FLOW_LSB     = SIZE_BITS;
  localparam int CE_BIT       = SIZE_BITS + FLOW_ID_BITS;
  localparam int QUANTA_LSB   = CE_BIT + 1;
  localparam int S_TDATA_W    = ((QUANTA_LSB + QUANTA_W + 7) / 8) * 8;
  localparam int M_TDATA_W    = ((STATUS_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_ARRIVE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PAUSE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TX_DONE = 2'd2;

  localparam logic [2:0] OP_ARRIVE = 3'd0;
  localparam logic [2:0] OP_PAUSE  = 3'd1;
  localparam logic [2:0] OP_RESUME = 3'd2;
  localparam logic [2:0] OP_DEPART = 3'd3;
  localparam logic [2:0] OP_NONE   = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_ENQ     = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_DROP    = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_DEPART  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_PAUSE   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED = 3'd4;

  localparam logic [LINK_W-1:0] LINK_READY         = 2'd0;
  localparam logic [LINK_W-1:0] LINK_PAUSE_PENDING = 2'd1;
  localparam logic [LINK_W-1:0] LINK_PAUSED        = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECN_THRESHOLD = 1'd1;

  localparam logic [BYTES_W-1:0] MAX_BYTES_RESET     = 24'd1048576;
  localparam logic [BYTES_W-1:0] ECN_THRESHOLD_RESET = 24'd65536;

  typedef struct packed {
    logic [2:0]              kind;
    logic                    ce;
    logic [FLOW_ID_BITS-1:0] flow;
    logic [SIZE_BITS-1:0]    size;
  } op_t;

endpackage

`default_nettype wire

// ----- hdl/ecnq_front.sv -----
// Front end: accepts stream requests, classifies them into operations and
// holds them in a two-entry queue for the back end. Depends on ecnq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecnq_front (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  // pkt_bytes, flow_id, ce_in, pause_quanta, zero fill
  input  wire  [ecnq_pkg::S_TDATA_W-1:0]  s_tdata,
  // cmd
  input  wire  [ecnq_pkg::CMD_W-1:0]      s_tuser,
  output logic                            op_valid,
  output ecnq_pkg::op_t                   op,
  input  wire                             op_pop
);
  import ecnq_pkg::*;

  op_t        new_op;
  op_t        q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    new_op.size = s_tdata[SIZE_BITS-1:0];
    new_op.flow = s_tdata[FLOW_LSB +: FLOW_ID_BITS];
    new_op.ce   = s_tdata[CE_BIT];
    case (s_tuser)
      CMD_ARRIVE:  new_op.kind = OP_ARRIVE;
      CMD_PAUSE: begin
        if (s_tdata[QUANTA_LSB +: QUANTA_W] != '0) new_op.kind = OP_PAUSE;
        else new_op.kind = OP_RESUME;
      end
      CMD_TX_DONE: new_op.kind = OP_DEPART;
      default:     new_op.kind = OP_NONE;
    endcase
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign op_valid = (count != 2'd0);
  assign op       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (op_pop) rd_ptr <= ~rd_ptr;
      case ({push, op_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= new_op;
  end

endmodule

`default_nettype wire

// ----- hdl/ecnq_back.sv -----
// Back end: configuration registers, descriptor memory, byte accounting,
// ECN marking, link pause state and the status output register.
// Depends on ecnq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecnq_back (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire  [ecnq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [ecnq_pkg::BYTES_W-1:0]    cfg_data,
  input  wire                             op_valid,
  input  ecnq_pkg::op_t                   op,
  output logic                            op_pop,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  // status, zero fill
  output logic [ecnq_pkg::M_TDATA_W-1:0]  m_tdata
);
  import ecnq_pkg::*;

  localparam logic S_RUN  = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                state;
  logic [BYTES_W-1:0]  max_bytes;
  logic [BYTES_W-1:0]  ecn_threshold;
  logic [PTR_W-1:0]    head_ptr;
  logic [PTR_W-1:0]    tail_ptr;
  logic [CNT_W-1:0]    entry_count;
  logic [BYTES_W-1:0]  queue_bytes;
  logic [LINK_W-1:0]   link_state;
  logic [31:0]         drop_count;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;

  logic [DESC_W-1:0]   mem [FIFO_DEPTH];
  logic [DESC_W-1:0]   rd_data;
  logic                rd_en;
  logic                wr_en;
  logic [PTR_W-1:0]    wr_addr;
  logic [DESC_W-1:0]   wr_data;

  logic                out_free;
  logic                go;
  logic                is_empty;
  logic                is_full;
  logic [BYTES_W:0]    sum;
  logic                over;
  logic                mark;
  logic [BYTES_W-1:0]  dsize;
  logic                enq_ok;
  logic [PTR_W-1:0]    head_inc;
  logic [PTR_W-1:0]    tail_inc;

  assign out_free = !out_valid || m_tready;
  assign go       = (state == S_RUN) && op_valid && out_free;
  assign op_pop   = go;
  assign is_empty = (entry_count == '0);
  assign is_full  = (entry_count == CNT_W'(FIFO_DEPTH));
  assign sum      = {1'b0, queue_bytes} + (BYTES_W + 1)'(op.size);
  assign over     = sum > {1'b0, max_bytes};
  assign enq_ok   = !over && !is_full;
  assign mark     = queue_bytes > ecn_threshold;
  assign dsize    = BYTES_W'(rd_data[SIZE_BITS-1:0]);
  assign head_inc = (head_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_ptr + PTR_W'(1);
  assign tail_inc = (tail_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_ptr + PTR_W'(1);

  assign rd_en   = go && (op.kind == OP_DEPART) && !is_empty;
  assign wr_en   = (state == S_READ) || (go && (op.kind == OP_ARRIVE) && enq_ok);
  assign wr_addr = (state == S_READ) ? head_ptr : tail_ptr;
  assign wr_data = (state == S_READ) ? {rd_data[DESC_W-1] | mark, rd_data[DESC_W-2:0]}
                                     : {op.ce, op.flow, op.size};

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'(out_status);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[head_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_RUN;
      max_bytes     <= MAX_BYTES_RESET;
      ecn_threshold <= ECN_THRESHOLD_RESET;
      head_ptr      <= '0;
      tail_ptr      <= '0;
      entry_count   <= '0;
      queue_bytes   <= '0;
      link_state    <= LINK_READY;
      drop_count    <= '0;
      out_valid     <= 1'b0;
      out_status    <= STATUS_ENQ;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_BYTES:     max_bytes <= cfg_data;
          REG_ECN_THRESHOLD: ecn_threshold <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && m_tready) out_valid <= 1'b0;
      case (state)
        S_RUN: begin
          if (go) begin
            case (op.kind)
              OP_ARRIVE: begin
                out_valid <= 1'b1;
                if (enq_ok) begin
                  tail_ptr    <= tail_inc;
                  entry_count <= entry_count + CNT_W'(1);
                  queue_bytes <= sum[BYTES_W-1:0];
                  out_status  <= STATUS_ENQ;
                end else begin
                  drop_count <= drop_count + 32'd1;
                  out_status <= STATUS_DROP;
                end
              end
              OP_PAUSE: begin
                link_state <= (queue_bytes != '0) ? LINK_PAUSE_PENDING : LINK_PAUSED;
                out_status <= STATUS_PAUSE;
                out_valid  <= 1'b1;
              end
              OP_RESUME: begin
                link_state <= LINK_READY;
                out_status <= STATUS_PAUSE;
                out_valid  <= 1'b1;
              end
              OP_DEPART: begin
                if (is_empty) begin
                  out_status <= STATUS_IGNORED;
                  out_valid  <= 1'b1;
                end else begin
                  state <= S_READ;
                end
              end
              default: begin
                out_status <= STATUS_IGNORED;
                out_valid  <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          head_ptr    <= head_inc;
          entry_count <= entry_count - CNT_W'(1);
          if (link_state == LINK_PAUSE_PENDING) link_state <= LINK_PAUSED;
          queue_bytes <= (queue_bytes >= dsize) ? queue_bytes - dsize : '0;
          out_status  <= STATUS_DEPART;
          out_valid   <= 1'b1;
          state       <= S_RUN;
        end
        default: state <= S_RUN;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(FIFO_DEPTH))
    else $error("descriptor count beyond memory depth");

  a_empty_no_bytes: assert property (@(posedge clk) disable iff (rst)
    is_empty |-> (queue_bytes == '0))
    else $error("bytes counted with no descriptor queued");

  a_read_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !out_valid)
    else $error("output register busy during descriptor read");

  a_read_completes: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_RUN) && out_valid && (out_status == STATUS_DEPART))
    else $error("departure did not complete after descriptor read");

endmodule

`default_nettype wire

// ----- hdl/ecn_marking_queue_with_pause.sv -----
// Output-port descriptor queue with byte occupancy, ECN CE marking on departure
// and link pause. A request passes the front queue and then the back end, so its
// status comes from the back end's output register; a transmit-done that removes
// a packet also passes the registered descriptor memory read. Arrivals, pause or
// resume frames, ignored commands and transmit-done on an empty queue finish in
// the run state; a transmit-done that removes a packet also passes the read state.
// A new request is taken every cycle while the two-entry front queue has room.
// Depends on ecnq_pkg, ecnq_front, ecnq_back.
`timescale 1ns / 1ps
`default_nettype none

module ecn_marking_queue_with_pause (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire  [ecnq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [ecnq_pkg::BYTES_W-1:0]    cfg_data,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  // pkt_bytes, flow_id, ce_in, pause_quanta, zero fill
  input  wire  [ecnq_pkg::S_TDATA_W-1:0]  s_tdata,
  // cmd
  input  wire  [ecnq_pkg::CMD_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  // status, zero fill
  output logic [ecnq_pkg::M_TDATA_W-1:0]  m_tdata
);
  import ecnq_pkg::*;

  logic op_valid;
  op_t  op;
  logic op_pop;

  ecnq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop)
  );

  ecnq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op_valid  (op_valid),
    .op        (op),
    .op_pop    (op_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire
